>>> rtl/core/pft_pkg.sv
// Shared types, codes and sizes for the Pauli frame tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pft_pkg;

    // Frame and record sizes
    localparam int QUBITS    = 256;
    localparam int QB_W      = $clog2(QUBITS);
    localparam int REC_W     = 12;
    localparam int QCNT_W    = 9;
    localparam int RCNT_W    = 13;
    localparam logic [QCNT_W-1:0] QCNT_RESET = QCNT_W'(256);
    localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(4096);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_QUBIT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT = 1'b1;

    // Operation codes on the input
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_CLEAR = 4'd0;
    localparam logic [OP_W-1:0] OP_H     = 4'd1;
    localparam logic [OP_W-1:0] OP_S     = 4'd2;
    localparam logic [OP_W-1:0] OP_CX    = 4'd3;
    localparam logic [OP_W-1:0] OP_CZ    = 4'd4;
    localparam logic [OP_W-1:0] OP_CY    = 4'd5;
    localparam logic [OP_W-1:0] OP_SWAP  = 4'd6;
    localparam logic [OP_W-1:0] OP_RESET = 4'd7;
    localparam logic [OP_W-1:0] OP_MEAS  = 4'd8;
    localparam logic [OP_W-1:0] OP_FAULT = 4'd9;

    // Pauli codes
    localparam logic [1:0] PAULI_I = 2'd0;
    localparam logic [1:0] PAULI_X = 2'd1;
    localparam logic [1:0] PAULI_Y = 2'd2;
    localparam logic [1:0] PAULI_Z = 2'd3;

    // Command queue sizing
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    // Classified command kinds
    typedef enum logic [3:0] {
        K_CLEAR = 4'd0,
        K_H     = 4'd1,
        K_S     = 4'd2,
        K_CX    = 4'd3,
        K_CZ    = 4'd4,
        K_CY    = 4'd5,
        K_SWAP  = 4'd6,
        K_RESET = 4'd7,
        K_MEAS  = 4'd8,
        K_FAULT = 4'd9,
        K_NOP   = 4'd10
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [QB_W-1:0]   qa;
        logic [QB_W-1:0]   qb;
        logic [1:0]        pa;
        logic [1:0]        pb;
        logic              emit;
        logic [REC_W-1:0]  rec;
    } t_cmd;

    typedef struct packed {
        logic [REC_W-1:0] idx;
        logic             flip;
    } t_res;

    // X component of a Pauli code
    function automatic logic pauli_x(input logic [1:0] p);
        pauli_x = (p == PAULI_X) || (p == PAULI_Y);
    endfunction

    // Z component of a Pauli code
    function automatic logic pauli_z(input logic [1:0] p);
        pauli_z = (p == PAULI_Y) || (p == PAULI_Z);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pft_front.sv
// Front end: holds the configuration registers, classifies each transaction
// and drops those with no effect. Depends on pft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pft_front
    import pft_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [QB_W-1:0]       i_qubit_a,
    input  wire logic [QB_W-1:0]       i_qubit_b,
    input  wire logic [1:0]            i_pauli_a,
    input  wire logic [1:0]            i_pauli_b,
    input  wire logic [REC_W-1:0]      i_record_bit,
    input  wire logic                  i_has_record,
    output logic                       o_cmd_push,
    output t_cmd                       o_cmd
);

    logic [QCNT_W-1:0] r_qubit_count;
    logic [RCNT_W-1:0] r_record_count;
    logic              a_ok;
    logic              b_ok;
    logic              rec_ok;
    logic [1:0]        pa_m;
    logic [1:0]        pb_m;
    t_cmd              cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubit_count  <= QCNT_RESET;
            r_record_count <= RCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUBIT_COUNT:  r_qubit_count  <= i_cfg_data[QCNT_W-1:0];
                CFG_RECORD_COUNT: r_record_count <= i_cfg_data[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Range checks
    assign a_ok   = {1'b0, i_qubit_a} < r_qubit_count;
    assign b_ok   = {1'b0, i_qubit_b} < r_qubit_count;
    assign rec_ok = {1'b0, i_record_bit} < r_record_count;
    assign pa_m   = a_ok ? i_pauli_a : PAULI_I;
    assign pb_m   = b_ok ? i_pauli_b : PAULI_I;

    // Classify the operation; anything without effect becomes a no-op
    always_comb begin
        cmd      = '0;
        cmd.kind = K_NOP;
        cmd.qa   = i_qubit_a;
        cmd.qb   = i_qubit_b;
        cmd.pa   = pa_m;
        cmd.pb   = pb_m;
        cmd.rec  = i_record_bit;
        cmd.emit = 1'b0;
        unique case (i_op)
            OP_CLEAR: cmd.kind = K_CLEAR;
            OP_H:     cmd.kind = a_ok ? K_H : K_NOP;
            OP_S:     cmd.kind = a_ok ? K_S : K_NOP;
            OP_RESET: cmd.kind = a_ok ? K_RESET : K_NOP;
            OP_CX:    cmd.kind = (a_ok && b_ok) ? K_CX : K_NOP;
            OP_CZ:    cmd.kind = (a_ok && b_ok) ? K_CZ : K_NOP;
            OP_CY:    cmd.kind = (a_ok && b_ok) ? K_CY : K_NOP;
            OP_SWAP:  cmd.kind = (a_ok && b_ok) ? K_SWAP : K_NOP;
            OP_MEAS: begin
                cmd.emit = a_ok && i_has_record;
                cmd.kind = cmd.emit ? K_MEAS : K_NOP;
            end
            OP_FAULT: begin
                cmd.emit = i_has_record && rec_ok;
                cmd.kind = (cmd.emit || pa_m != PAULI_I || pb_m != PAULI_I)
                           ? K_FAULT : K_NOP;
            end
            default: cmd.kind = K_NOP;
        endcase
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept && (cmd.kind != K_NOP);

`ifndef SYNTHESIS
    a_push_not_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> (o_cmd.kind != K_NOP))
        else $error("front pushed a no-op command");
    a_gate_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && (o_cmd.kind == K_CX || o_cmd.kind == K_SWAP))
        |-> ({1'b0, o_cmd.qb} < r_qubit_count))
        else $error("two-qubit gate pushed with out-of-range qubit");
    a_emit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && o_cmd.emit)
        |-> (o_cmd.kind == K_MEAS || o_cmd.kind == K_FAULT))
        else $error("result requested by a command that cannot give one");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pft_cmd_queue.sv
// Short command queue between front end and execution back end.
// Depends on pft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pft_cmd_queue
    import pft_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wp;
    logic [CMD_AW-1:0] r_rp;
    logic [CMD_AW:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (CMD_AW + 1)'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (CMD_AW + 1)'(CMD_DEPTH))
        else $error("command queue occupancy beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != (CMD_AW + 1)'(CMD_DEPTH))
        |-> (r_wp == r_rp + r_cnt[CMD_AW-1:0]))
        else $error("command queue pointers disagree with occupancy");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pft_back.sv
// Back end: holds the X and Z frame bits, runs one command a cycle unless
// its result lacks room, queues result transactions. Depends on pft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pft_back
    import pft_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_empty,
    input  wire t_cmd                 i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output logic [REC_W-1:0]          o_flip_index,
    output logic                      o_flip
);

    localparam int RES_DEPTH = 2;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    logic [QUBITS-1:0] r_x;
    logic [QUBITS-1:0] r_z;
    t_res              r_res [RES_DEPTH];
    logic [RES_AW-1:0] r_res_wp;
    logic [RES_AW-1:0] r_res_rp;
    logic [RES_AW:0]   r_res_cnt;

    logic xa, za, xb, zb;
    logic n_xa, n_za, n_xb, n_zb;
    logic zb1, xb1;
    logic wr_a, wr_b, clr;
    logic same;
    logic step;
    logic res_full;
    logic res_push;
    logic res_pop;
    t_res res_new;

    // Read both named qubits
    assign xa   = r_x[i_cmd.qa];
    assign za   = r_z[i_cmd.qa];
    assign xb   = r_x[i_cmd.qb];
    assign zb   = r_z[i_cmd.qb];
    assign same = (i_cmd.qa == i_cmd.qb);

    // Conjugation rules; a repeated qubit takes the sequential outcome
    always_comb begin
        n_xa = xa;
        n_za = za;
        n_xb = xb;
        n_zb = zb;
        wr_a = 1'b0;
        wr_b = 1'b0;
        clr  = 1'b0;
        zb1  = zb ^ xb;
        xb1  = xb ^ xa;
        unique case (i_cmd.kind)
            K_CLEAR: clr = 1'b1;
            K_H: begin
                wr_a = 1'b1;
                n_xa = za;
                n_za = xa;
            end
            K_S: begin
                wr_a = 1'b1;
                n_za = za ^ xa;
            end
            K_RESET: begin
                wr_a = 1'b1;
                n_xa = 1'b0;
                n_za = 1'b0;
            end
            K_CX: begin
                wr_a = 1'b1;
                if (same) begin
                    n_xa = 1'b0;
                    n_za = 1'b0;
                end else begin
                    wr_b = 1'b1;
                    n_xb = xb ^ xa;
                    n_za = za ^ zb;
                end
            end
            K_CZ: begin
                if (!same) begin
                    wr_a = 1'b1;
                    wr_b = 1'b1;
                    n_za = za ^ xb;
                    n_zb = zb ^ xa;
                end
            end
            K_CY: begin
                wr_a = 1'b1;
                if (same) begin
                    n_xa = 1'b0;
                    n_za = 1'b0;
                end else begin
                    wr_b = 1'b1;
                    n_xb = xb1;
                    n_za = za ^ zb1;
                    n_zb = zb1 ^ xb1;
                end
            end
            K_SWAP: begin
                if (!same) begin
                    wr_a = 1'b1;
                    wr_b = 1'b1;
                    n_xa = xb;
                    n_za = zb;
                    n_xb = xa;
                    n_zb = za;
                end
            end
            K_FAULT: begin
                wr_a = 1'b1;
                if (same) begin
                    n_xa = xa ^ pauli_x(i_cmd.pa) ^ pauli_x(i_cmd.pb);
                    n_za = za ^ pauli_z(i_cmd.pa) ^ pauli_z(i_cmd.pb);
                end else begin
                    wr_b = 1'b1;
                    n_xa = xa ^ pauli_x(i_cmd.pa);
                    n_za = za ^ pauli_z(i_cmd.pa);
                    n_xb = xb ^ pauli_x(i_cmd.pb);
                    n_zb = zb ^ pauli_z(i_cmd.pb);
                end
            end
            default: ;
        endcase
    end

    // Execute when a command waits and its result has room
    assign res_full      = (r_res_cnt == (RES_AW + 1)'(RES_DEPTH));
    assign step          = !i_cmd_empty && (!i_cmd.emit || !res_full);
    assign o_cmd_pop     = step;
    assign res_push      = step && i_cmd.emit;
    assign res_new.idx   = i_cmd.rec;
    assign res_new.flip  = (i_cmd.kind == K_MEAS) ? xa : 1'b1;

    // Update the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_z <= '0;
        end else if (step) begin
            if (clr) begin
                r_x <= '0;
                r_z <= '0;
            end else begin
                if (wr_a) begin
                    r_x[i_cmd.qa] <= n_xa;
                    r_z[i_cmd.qa] <= n_za;
                end
                if (wr_b) begin
                    r_x[i_cmd.qb] <= n_xb;
                    r_z[i_cmd.qb] <= n_zb;
                end
            end
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wp] <= res_new;
        end
    end

    // Result queue pointers and occupancy
    assign o_empty = (r_res_cnt == '0);
    assign res_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wp  <= '0;
            r_res_rp  <= '0;
            r_res_cnt <= '0;
        end else begin
            if (res_push) begin
                r_res_wp <= r_res_wp + 1'b1;
            end
            if (res_pop) begin
                r_res_rp <= r_res_rp + 1'b1;
            end
            if (res_push && !res_pop) begin
                r_res_cnt <= r_res_cnt + 1'b1;
            end else if (res_pop && !res_push) begin
                r_res_cnt <= r_res_cnt - 1'b1;
            end
        end
    end

    assign o_flip_index = r_res[r_res_rp].idx;
    assign o_flip       = r_res[r_res_rp].flip;

`ifndef SYNTHESIS
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_cmd.kind == K_CLEAR) |=> (r_x == '0 && r_z == '0))
        else $error("frame not zero after clear");
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");
    a_fault_flip_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && i_cmd.kind == K_FAULT) |-> res_new.flip)
        else $error("fault result without a flip");
    a_res_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= (RES_AW + 1)'(RES_DEPTH))
        else $error("result queue occupancy beyond depth");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pauli_frame_tracker.sv
// Pauli frame tracker, top level: front end, command queue and back end.
// Depends on pft_pkg, pft_front, pft_cmd_queue and pft_back.
//
// Tracks one X and one Z bit per qubit (256 qubits, all held in flip-flops)
// through a stream of Clifford gates, measures and fault events. An operation
// is taken on every cycle in which push is high and full is low, so the
// sustained rate is one operation per clock while the result queue has room;
// a clear of the whole frame is a single command too. Every operation reads
// and rewrites at most two qubits' frame bits in one pass of the back end,
// which sets that rate. A result (record index plus flip) passes through the
// registered command queue and result queue before it reaches the result
// ports. Operations with no effect (no-ops, gates on out-of-range qubits,
// measures without a record) are dropped on entry and give no result.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data, by the
// user only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module pauli_frame_tracker
    import pft_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [QB_W-1:0]       i_qubit_a,
    input  wire logic [QB_W-1:0]       i_qubit_b,
    input  wire logic [1:0]            i_pauli_a,
    input  wire logic [1:0]            i_pauli_b,
    input  wire logic [REC_W-1:0]      i_record_bit,
    input  wire logic                  i_has_record,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [REC_W-1:0]           o_flip_index,
    output logic                       o_flip
);

    logic accept;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    assign accept = push && !full;

    // Classify incoming transactions
    pft_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_qubit_a    (i_qubit_a),
        .i_qubit_b    (i_qubit_b),
        .i_pauli_a    (i_pauli_a),
        .i_pauli_b    (i_pauli_b),
        .i_record_bit (i_record_bit),
        .i_has_record (i_has_record),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    // Decouple front and back
    pft_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    // Execute on the frame and deliver results
    pft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (cmd_empty),
        .i_cmd        (cmd_out),
        .o_cmd_pop    (cmd_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_flip_index (o_flip_index),
        .o_flip       (o_flip)
    );

endmodule

`default_nettype wire
